// ===== hdl/tiu_pkg.sv =====
`timescale 1ns / 1ps

package tiu_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_FACTOR = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 12;
  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 24;
  localparam int FRAC_W    = 8;

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;

  localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int ACC_W  = DIFF_W + FAC_W + 1;
  localparam int MAG_W  = SAMPLE_W + $clog2(2 * MAX_FACTOR);
  localparam int DIV_W  = MAG_W + FRAC_W;
  localparam int RES_W  = DIV_W + 1;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR      = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [FAC_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [FAC_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/triangle_interp_upsampler.sv =====
// Loads are written to the sample memory when accepted, so they can follow back to back.
// An in-range query computes its result word with the shared
// bit-serial divider: 12 steps for each cell coordinate and 31 for the final division.
// An out-of-range query goes from S_CHECK straight to S_DONE with a zero result word.
// Input is stalled until a query's result word has entered the output register.
// Reset sets all three registers to 2; the samples are not cleared.
`timescale 1ns / 1ps

module triangle_interp_upsampler
  import tiu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_opcode_i,
  input  logic [ROW_W-1:0]     in_sample_row_i,
  input  logic [COL_W-1:0]     in_sample_col_i,
  input  logic [SAMPLE_W-1:0]  in_sample_value_i,
  input  logic [COORD_W-1:0]   in_out_row_i,
  input  logic [COORD_W-1:0]   in_out_col_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VALUE_W-1:0]   out_value_o,
  output logic                 out_out_of_range_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIVY  = 4'd2;
  localparam logic [3:0] S_WAITY = 4'd3;
  localparam logic [3:0] S_DIVX  = 4'd4;
  localparam logic [3:0] S_WAITX = 4'd5;
  localparam logic [3:0] S_RD0   = 4'd6;
  localparam logic [3:0] S_RD1   = 4'd7;
  localparam logic [3:0] S_RD2   = 4'd8;
  localparam logic [3:0] S_RD3   = 4'd9;
  localparam logic [3:0] S_MUL1  = 4'd10;
  localparam logic [3:0] S_MUL2  = 4'd11;
  localparam logic [3:0] S_DIVF  = 4'd12;
  localparam logic [3:0] S_WAITF = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d;

  logic [CFG_W-1:0] width_q, height_q, factor_q;
  logic [CFG_W-1:0] w_eff, h_eff, f_eff;

  logic [COORD_W-1:0] oy_q, ox_q;
  logic [ROW_W-1:0]   row_lo_q, row_lo_d, row_hi_q, row_hi_d;
  logic [COL_W-1:0]   col_lo_q, col_lo_d, col_hi_q, col_hi_d;
  logic [FAC_W-1:0]   by_q, by_d, bx_q, bx_d;
  logic [SAMPLE_W-1:0] a00_q, a00_d, second_q, second_d, third_q, third_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;
  logic               res_oor_q, res_oor_d;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_oor_q;

  logic [SAMPLE_W-1:0] sample_mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]   rd_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic load_we;
  logic lower;
  logic out_free;

  logic [2*CFG_W-1:0]  lim_y, lim_x;
  logic [COORD_W-1:0]  cell_q, h_lim, w_lim;
  logic                clamp_y, clamp_x;

  logic signed [DIFF_W-1:0] diff1, diff2, mul_a;
  logic        [FAC_W-1:0]  w2, mul_w;
  logic signed [ACC_W-1:0]  prod;
  logic        [ACC_W-1:0]  mag;
  logic        [RES_W-1:0]  uq, qs, base, sum;

  tiu_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    w_eff = (width_q == '0) ? CFG_W'(1) :
            (width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q;
    h_eff = (height_q == '0) ? CFG_W'(1) :
            (height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;
    f_eff = (factor_q == '0) ? CFG_W'(1) :
            (factor_q > CFG_W'(MAX_FACTOR)) ? CFG_W'(MAX_FACTOR) : factor_q;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_we     = in_acc && (in_opcode_i == OP_LOAD);
  assign cfg_ready_o = 1'b1;
  assign lower       = (bx_q <= by_q);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(2);
      height_q <= CFG_W'(2);
      factor_q <= CFG_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: height_q <= cfg_data_i;
        CFG_FACTOR:      factor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_addr = {row_lo_q, col_lo_q};
    case (state_q)
      S_RD1:   rd_addr = lower ? {row_hi_q, col_lo_q} : {row_hi_q, col_hi_q};
      S_RD2:   rd_addr = lower ? {row_hi_q, col_hi_q} : {row_lo_q, col_hi_q};
      default: rd_addr = {row_lo_q, col_lo_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      sample_mem[{in_sample_row_i, in_sample_col_i}] <= in_sample_value_i;
    end
    rd_data_q <= sample_mem[rd_addr];
  end

  always_comb begin
    lim_y   = (2*CFG_W)'(h_eff - CFG_W'(1)) * (2*CFG_W)'(f_eff);
    lim_x   = (2*CFG_W)'(w_eff - CFG_W'(1)) * (2*CFG_W)'(f_eff);
    cell_q  = div_rsp.quotient[COORD_W-1:0];
    h_lim   = COORD_W'(h_eff) - COORD_W'(2);
    w_lim   = COORD_W'(w_eff) - COORD_W'(2);
    clamp_y = (h_eff >= CFG_W'(2)) && (cell_q > h_lim);
    clamp_x = (w_eff >= CFG_W'(2)) && (cell_q > w_lim);

    diff1 = $signed({second_q[SAMPLE_W-1], second_q}) - $signed({a00_q[SAMPLE_W-1], a00_q});
    diff2 = lower ?
            $signed({third_q[SAMPLE_W-1], third_q}) - $signed({second_q[SAMPLE_W-1], second_q}) :
            $signed({third_q[SAMPLE_W-1], third_q}) - $signed({a00_q[SAMPLE_W-1], a00_q});
    w2    = lower ? bx_q : (bx_q - by_q);
    mul_a = (state_q == S_MUL2) ? diff2 : diff1;
    mul_w = (state_q == S_MUL2) ? w2 : by_q;
    prod  = ACC_W'(mul_a * $signed({1'b0, mul_w}));

    mag  = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
    uq   = {1'b0, div_rsp.quotient};
    qs   = neg_q ? (~(uq + RES_W'(div_rsp.remainder != '0)) + RES_W'(1)) : uq;
    base = {{(RES_W-SAMPLE_W-FRAC_W){a00_q[SAMPLE_W-1]}}, a00_q, {FRAC_W{1'b0}}};
    sum  = base + qs;
  end

  always_comb begin
    state_d     = state_q;
    row_lo_d    = row_lo_q;
    row_hi_d    = row_hi_q;
    col_lo_d    = col_lo_q;
    col_hi_d    = col_hi_q;
    by_d        = by_q;
    bx_d        = bx_q;
    a00_d       = a00_q;
    second_d    = second_q;
    third_d     = third_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    res_value_d = res_value_q;
    res_oor_d   = res_oor_q;

    div_req.start    = 1'b0;
    div_req.steps    = STEP_W'(COORD_W);
    div_req.dividend = {oy_q, {(DIV_W-COORD_W){1'b0}}};
    div_req.divisor  = f_eff;

    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_opcode_i == OP_QUERY)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (({2'b00, oy_q} > lim_y) || ({2'b00, ox_q} > lim_x)) begin
          res_value_d = '0;
          res_oor_d   = 1'b1;
          state_d     = S_DONE;
        end else begin
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        div_req.start = 1'b1;
        state_d       = S_WAITY;
      end
      S_WAITY: begin
        if (div_rsp.done) begin
          row_lo_d = clamp_y ? h_lim[ROW_W-1:0] : cell_q[ROW_W-1:0];
          by_d     = clamp_y ? f_eff : div_rsp.remainder;
          row_hi_d = (h_eff >= CFG_W'(2)) ? (row_lo_d + ROW_W'(1)) : row_lo_d;
          state_d  = S_DIVX;
        end
      end
      S_DIVX: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ox_q, {(DIV_W-COORD_W){1'b0}}};
        state_d          = S_WAITX;
      end
      S_WAITX: begin
        if (div_rsp.done) begin
          col_lo_d = clamp_x ? w_lim[COL_W-1:0] : cell_q[COL_W-1:0];
          bx_d     = clamp_x ? f_eff : div_rsp.remainder;
          col_hi_d = (w_eff >= CFG_W'(2)) ? (col_lo_d + COL_W'(1)) : col_lo_d;
          state_d  = S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        a00_d   = rd_data_q;
        state_d = S_RD2;
      end
      S_RD2: begin
        second_d = rd_data_q;
        state_d  = S_RD3;
      end
      S_RD3: begin
        third_d = rd_data_q;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        acc_d   = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = acc_q + prod;
        state_d = S_DIVF;
      end
      S_DIVF: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(DIV_W);
        div_req.dividend = {mag[MAG_W-1:0], {FRAC_W{1'b0}}};
        neg_d            = acc_q[ACC_W-1];
        state_d          = S_WAITF;
      end
      S_WAITF: begin
        if (div_rsp.done) begin
          res_value_d = sum[VALUE_W-1:0];
          res_oor_d   = 1'b0;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      oy_q <= in_out_row_i;
      ox_q <= in_out_col_i;
    end
    row_lo_q    <= row_lo_d;
    row_hi_q    <= row_hi_d;
    col_lo_q    <= col_lo_d;
    col_hi_q    <= col_hi_d;
    by_q        <= by_d;
    bx_q        <= bx_d;
    a00_q       <= a00_d;
    second_q    <= second_d;
    third_q     <= third_d;
    acc_q       <= acc_d;
    neg_q       <= neg_d;
    res_value_q <= res_value_d;
    res_oor_q   <= res_oor_d;
    if (state_q == S_DONE && out_free) begin
      out_value_q <= res_value_q;
      out_oor_q   <= res_oor_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_value_o        = out_value_q;
  assign out_out_of_range_o = out_oor_q;

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_opcode_i == OP_QUERY) |=> (state_q == S_CHECK))
    else $error("Accepted query did not start the sequencer.");

  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_opcode_i == OP_LOAD && !out_valid_o) |=> !out_valid_o)
    else $error("A load produced a result word.");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("Divider finished without running.");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_out_of_range_o) |-> (out_value_o == '0))
    else $error("Out-of-range word carries a nonzero value.");

endmodule

// ===== hdl/tiu_divider.sv =====
`timescale 1ns / 1ps

module tiu_divider
  import tiu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  quo_q;
  logic [FAC_W-1:0]  rem_q;
  logic [FAC_W-1:0]  divisor_q;

  logic [FAC_W:0]   rem_shift;
  logic [FAC_W:0]   rem_diff;
  logic             take;
  logic [FAC_W-1:0] rem_next;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor_q};
    take      = rem_shift >= {1'b0, divisor_q};
    rem_next  = take ? rem_diff[FAC_W-1:0] : rem_shift[FAC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], take};
      rem_q <= rem_next;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
